// ===== hw/rtl/hlsf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hlsf_pkg;

  localparam logic [7:0] NEWLINE   = 8'h0a;
  localparam logic [7:0] NUL_CHAR  = 8'h00;
  localparam logic [7:0] SYNC_BYTE = 8'hff;
  localparam logic [7:0] HDR_ZERO  = 8'h00;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_CHARS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_LENGTH = 2'd2;

  localparam logic [2:0]  PREFIX_LENGTH_RST   = 3'd3;
  localparam logic [31:0] PREFIX_CHARS_RST    = 32'h0020_3130;
  localparam logic [4:0]  EXPECTED_LENGTH_RST = 5'd29;
  localparam logic [2:0]  PREFIX_MAX          = 3'd4;

  typedef enum logic [1:0] {
    LS_OK,
    LS_MISMATCH,
    LS_VOIDED,
    LS_STOPPED
  } line_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR_FF,
    ST_HDR_00,
    ST_READ,
    ST_DATA,
    ST_STUFF
  } emit_state_t;

  // {valid, value}
  function automatic logic [4:0] decode_hex(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - "0")};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hlsf_channels.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface hlsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_text;

  modport source (output valid, output ch, output end_of_text, input ready);
  modport sink (input valid, input ch, input end_of_text, output ready);
endinterface

interface hlsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink (input valid, input out_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hlsf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hlsf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hex_line_to_stuffed_frame.sv =====
// Hex text line to byte-stuffed binary frame.
// in_ch: one text character per word (ch, end_of_text), valid/ready.
// out_ch: one binary byte per word (out_byte, frame_end), valid/ready.
// cfg_*: write-only register port (prefix length, prefix chars, expected length);
// write only while idle.
// Characters that do not close a line are accepted back to back, decoded bytes
// going straight into the frame RAM. A closing line whose prefix matches and
// whose byte count equals the expected length emits FF 00, then the stored
// bytes, every FF sent twice, frame_end on the last byte. The closing character
// sets the state register, which then loads FF into the output register; each
// stored byte is read from RAM, then loaded, a stuffed FF once more. in_ch.ready
// stays low until the last byte of a frame is in the output register.
// A stalled receiver holds the output register and the emission sequencer.
// Reset restores the register defaults and clears the line state; frame RAM
// contents are not cleared (entries are read only after being written).
`timescale 1ns / 1ps
`default_nettype none

module hex_line_to_stuffed_frame #(
  parameter int unsigned MAX_FRAME_BYTES = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [hlsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hlsf_pkg::CFG_DATA_W-1:0] cfg_data,
  hlsf_in_if.sink                              in_ch,
  hlsf_out_if.source                           out_ch
);

  import hlsf_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_FRAME_BYTES);
  localparam int unsigned BCW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned CW  = (BCW > 5) ? BCW : 5;

  logic [2:0]     prefix_length;
  logic [31:0]    prefix_chars;
  logic [4:0]     expected_length;

  emit_state_t    state, state_next;
  logic [BCW-1:0] byte_count, byte_count_next;
  logic [4:0]     pending_nibble, pending_nibble_next;
  logic [2:0]     line_position, line_position_next;
  line_status_t   line_status, line_status_next;
  logic [BCW-1:0] emit_len, emit_len_next;
  logic [BCW-1:0] emit_idx, emit_idx_next;

  logic           out_valid;
  logic [7:0]     out_byte_r, out_byte_next;
  logic           frame_end_r, frame_end_next;
  logic           out_load;
  logic           out_free;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;
  logic           ram_re;
  logic [7:0]     ram_rdata;

  logic [2:0]     eff_len;
  logic [31:0]    prefix_sh;
  logic [4:0]     nib;
  logic [BCW-1:0] idx_inc;
  logic           last;
  logic           matched;

  hlsf_ram #(
    .WIDTH(8),
    .DEPTH(MAX_FRAME_BYTES)
  ) u_frame_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(emit_idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign in_ch.ready      = (state == ST_IDLE);
  assign out_ch.valid     = out_valid;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.frame_end = frame_end_r;

  assign eff_len   = (prefix_length > PREFIX_MAX) ? PREFIX_MAX : prefix_length;
  assign prefix_sh = prefix_chars >> {line_position[1:0], 3'b000};
  assign nib       = decode_hex(in_ch.ch);
  assign out_free  = !out_valid || out_ch.ready;
  assign idx_inc   = emit_idx + BCW'(1);
  assign last      = (idx_inc == emit_len);
  assign ram_waddr = byte_count[AW-1:0];
  assign ram_wdata = {pending_nibble[3:0], nib[3:0]};

  always_comb begin
    state_next          = state;
    byte_count_next     = byte_count;
    pending_nibble_next = pending_nibble;
    line_position_next  = line_position;
    line_status_next    = line_status;
    emit_len_next       = emit_len;
    emit_idx_next       = emit_idx;
    out_load            = 1'b0;
    out_byte_next       = out_byte_r;
    frame_end_next      = frame_end_r;
    ram_we              = 1'b0;
    ram_re              = 1'b0;
    matched             = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.ch != NEWLINE && line_status == LS_OK) begin
            if (line_position < eff_len) begin
              if (in_ch.ch != prefix_sh[7:0]) begin
                line_status_next = LS_MISMATCH;
              end else begin
                line_position_next = line_position + 3'd1;
              end
            end else if (in_ch.ch == NUL_CHAR) begin
              line_status_next = LS_STOPPED;
            end else if (!nib[4]) begin
              line_status_next    = LS_VOIDED;
              byte_count_next     = '0;
              pending_nibble_next = 5'd0;
            end else if (!pending_nibble[4]) begin
              pending_nibble_next = nib;
            end else if (byte_count >= BCW'(MAX_FRAME_BYTES)) begin
              line_status_next = LS_STOPPED;
            end else begin
              ram_we              = 1'b1;
              byte_count_next     = byte_count + BCW'(1);
              pending_nibble_next = 5'd0;
            end
          end
          if (in_ch.ch == NEWLINE || in_ch.end_of_text) begin
            matched = (line_status_next != LS_MISMATCH) && (line_position_next >= eff_len);
            if (matched && CW'(byte_count_next) == CW'(expected_length)) begin
              emit_len_next = byte_count_next;
              emit_idx_next = '0;
              state_next    = ST_HDR_FF;
            end
            byte_count_next     = '0;
            pending_nibble_next = 5'd0;
            line_position_next  = 3'd0;
            line_status_next    = LS_OK;
          end
        end
      end
      ST_HDR_FF: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_byte_next  = SYNC_BYTE;
          frame_end_next = 1'b0;
          state_next     = ST_HDR_00;
        end
      end
      ST_HDR_00: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_byte_next  = HDR_ZERO;
          frame_end_next = (emit_len == '0);
          state_next     = (emit_len == '0) ? ST_IDLE : ST_READ;
        end
      end
      ST_READ: begin
        ram_re     = 1'b1;
        state_next = ST_DATA;
      end
      ST_DATA: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_byte_next  = ram_rdata;
          frame_end_next = last && (ram_rdata != SYNC_BYTE);
          if (ram_rdata == SYNC_BYTE) begin
            state_next = ST_STUFF;
          end else begin
            emit_idx_next = idx_inc;
            state_next    = last ? ST_IDLE : ST_READ;
          end
        end
      end
      ST_STUFF: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_byte_next  = SYNC_BYTE;
          frame_end_next = last;
          emit_idx_next  = idx_inc;
          state_next     = last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      prefix_length   <= PREFIX_LENGTH_RST;
      prefix_chars    <= PREFIX_CHARS_RST;
      expected_length <= EXPECTED_LENGTH_RST;
      byte_count      <= '0;
      pending_nibble  <= 5'd0;
      line_position   <= 3'd0;
      line_status     <= LS_OK;
      emit_len        <= '0;
      emit_idx        <= '0;
      out_valid       <= 1'b0;
    end else begin
      state          <= state_next;
      byte_count     <= byte_count_next;
      pending_nibble <= pending_nibble_next;
      line_position  <= line_position_next;
      line_status    <= line_status_next;
      emit_len       <= emit_len_next;
      emit_idx       <= emit_idx_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PREFIX_LENGTH:   prefix_length   <= cfg_data[2:0];
          REG_PREFIX_CHARS:    prefix_chars    <= cfg_data[31:0];
          REG_EXPECTED_LENGTH: expected_length <= cfg_data[4:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r  <= out_byte_next;
      frame_end_r <= frame_end_next;
    end
  end

endmodule

`default_nettype wire

// ===== sim/hlsf_frame_checker.sv =====
`timescale 1ns / 1ps

module hlsf_frame_checker #(
  parameter int unsigned MAX_FRAME_BYTES = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hlsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hlsf_pkg::CFG_DATA_W-1:0] cfg_data,
  hlsf_in_if                              in_mon,
  hlsf_out_if                             out_mon,
  output int unsigned                     fail_count,
  output int unsigned                     due_words
);

  import hlsf_pkg::*;

  localparam int unsigned AW = $clog2(MAX_FRAME_BYTES);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_word_t;

  logic [2:0]   pfx_len;
  logic [31:0]  pfx_chars;
  logic [4:0]   exp_len;

  logic [7:0]   frame_mem [MAX_FRAME_BYTES];
  logic [5:0]   held_bytes;
  logic [4:0]   pend;
  logic [2:0]   match_pos;
  line_status_t line_st;

  frame_word_t  due_q [$];
  frame_word_t  want;
  int unsigned  fails;

  function automatic logic [2:0] prefix_span();
    return (pfx_len > PREFIX_MAX) ? PREFIX_MAX : pfx_len;
  endfunction

  task automatic absorb_char(input logic [7:0] c);
    logic [3:0] digit;
    logic       is_digit;
    if (line_st != LS_OK) return;
    if (match_pos < prefix_span()) begin
      if (c != pfx_chars[{match_pos[1:0], 3'b000} +: 8]) line_st = LS_MISMATCH;
      else match_pos = match_pos + 3'd1;
      return;
    end
    if (c == NUL_CHAR) begin
      line_st = LS_STOPPED;
      return;
    end
    is_digit = 1'b1;
    digit = 4'd0;
    if (c >= "0" && c <= "9") begin
      digit = c[3:0];
    end else if ((c | 8'h20) >= "a" && (c | 8'h20) <= "f") begin
      digit = c[3:0] + 4'd9;
    end else begin
      is_digit = 1'b0;
    end
    if (!is_digit) begin
      line_st = LS_VOIDED;
      held_bytes = '0;
      pend = '0;
      return;
    end
    if (!pend[4]) begin
      pend = {1'b1, digit};
      return;
    end
    if (held_bytes >= MAX_FRAME_BYTES) begin
      line_st = LS_STOPPED;
      return;
    end
    frame_mem[held_bytes[AW-1:0]] = {pend[3:0], digit};
    held_bytes = held_bytes + 6'd1;
    pend = '0;
  endtask

  // line end: queue FF 00 + stuffed bytes when prefix and length agree
  task automatic queue_frame();
    int         i;
    logic [7:0] b;
    logic       matched;
    matched = (line_st != LS_MISMATCH) && (match_pos >= prefix_span());
    if (matched && held_bytes == {1'b0, exp_len}) begin
      due_q.push_back({SYNC_BYTE, 1'b0});
      due_q.push_back({HDR_ZERO, held_bytes == 6'd0});
      for (i = 0; i < int'(held_bytes); i++) begin
        b = frame_mem[AW'(i)];
        due_q.push_back({b, (i == int'(held_bytes) - 1) && (b != SYNC_BYTE)});
        if (b == SYNC_BYTE) due_q.push_back({b, i == int'(held_bytes) - 1});
      end
    end
    held_bytes = '0;
    pend = '0;
    match_pos = '0;
    line_st = LS_OK;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pfx_len = PREFIX_LENGTH_RST;
      pfx_chars = PREFIX_CHARS_RST;
      exp_len = EXPECTED_LENGTH_RST;
      held_bytes = '0;
      pend = '0;
      match_pos = '0;
      line_st = LS_OK;
      due_q.delete();
      fails = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PREFIX_LENGTH:   pfx_len = cfg_data[2:0];
          REG_PREFIX_CHARS:    pfx_chars = cfg_data;
          REG_EXPECTED_LENGTH: exp_len = cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.ch != NEWLINE) absorb_char(in_mon.ch);
        if (in_mon.ch == NEWLINE || in_mon.end_of_text) queue_frame();
      end
      if (out_mon.valid && out_mon.ready) begin
        if (due_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected word: expected none, actual byte %02h frame_end %0b",
                   $time, out_mon.out_byte, out_mon.frame_end);
        end else begin
          want = due_q.pop_front();
          if (out_mon.out_byte != want.data) begin
            fails++;
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.data, out_mon.out_byte);
          end
          if (out_mon.frame_end != want.last) begin
            fails++;
            $display("%0t: frame_end mismatch: expected %0b, actual %0b",
                     $time, want.last, out_mon.frame_end);
          end
        end
      end
    end
    fail_count <= fails;
    due_words <= due_q.size();
  end

endmodule

// ===== sim/hex_line_to_stuffed_frame_test.sv =====
`timescale 1ns / 1ps

module hex_line_to_stuffed_frame_test;
  import hlsf_pkg::*;

  localparam int unsigned FRAME_BYTES   = 32;
  localparam int unsigned RANDOM_CHARS  = 360;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned IDLE_LIMIT    = 2000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hlsf_in_if  in_ch ();
  hlsf_out_if out_ch ();

  int unsigned fail_count;
  int unsigned due_words;

  logic        sink_ready = 1'b0;
  int unsigned sink_mode = 0;
  int unsigned sink_hold = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned sent_chars = 0;

  logic [2:0]  cur_plen;
  logic [31:0] cur_chars;
  logic [4:0]  cur_elen;

  hex_line_to_stuffed_frame #(
    .MAX_FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  hlsf_frame_checker #(
    .MAX_FRAME_BYTES(FRAME_BYTES)
  ) frame_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .fail_count(fail_count),
    .due_words (due_words)
  );

  assign out_ch.ready = sink_ready;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: mode switches every so often between steady, light, even and heavy stalls
  always @(posedge clk) begin
    if (sink_hold == 0) begin
      sink_mode <= $urandom_range(0, 3);
      sink_hold <= $urandom_range(20, 200);
    end else begin
      sink_hold <= sink_hold - 1;
    end
    case (sink_mode)
      0: sink_ready <= 1'b1;
      1: sink_ready <= ($urandom_range(0, 3) != 0);
      2: sink_ready <= ($urandom_range(0, 3) == 0);
      default: sink_ready <= $urandom_range(0, 1);
    endcase
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic eot);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.ch <= c;
    in_ch.end_of_text <= eot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_chars++;
  endtask

  task automatic send_text(input string s, input logic eot_last);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], eot_last && (i == s.len() - 1));
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_words != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [2:0] plen, input logic [31:0] chars,
                            input logic [4:0] elen);
    cur_plen = plen;
    cur_chars = chars;
    cur_elen = elen;
    cfg_we <= 1'b1;
    cfg_index <= REG_PREFIX_LENGTH;
    cfg_data <= 32'(plen);
    @(posedge clk);
    cfg_index <= REG_PREFIX_CHARS;
    cfg_data <= chars;
    @(posedge clk);
    cfg_index <= REG_EXPECTED_LENGTH;
    cfg_data <= 32'(elen);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    if ($urandom_range(0, 1) == 0) return "a" + 8'(n) - 8'd10;
    return "A" + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    c = NEWLINE;
    while (c == NEWLINE || (c >= "0" && c <= "9") ||
           ((c | 8'h20) >= "a" && (c | 8'h20) <= "f"))
      c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  // mostly well-formed lines for the current setting, the rest broken or noise
  task automatic send_random_line();
    logic [7:0]  txt [$];
    logic [7:0]  b;
    int unsigned span, kind, nbytes, i, pos, ending, keep;
    span = (cur_plen > PREFIX_MAX) ? PREFIX_MAX : cur_plen;
    kind = $urandom_range(0, 99);
    nbytes = cur_elen;
    if (kind >= 60 && kind < 70)
      nbytes = (cur_elen == 0 || $urandom_range(0, 1) == 1) ? cur_elen + 1 : cur_elen - 1;
    else if (kind >= 96)
      nbytes = FRAME_BYTES + $urandom_range(1, 2);
    for (i = 0; i < span; i++) txt.push_back(cur_chars[8*i +: 8]);
    for (i = 0; i < nbytes; i++) begin
      b = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom());
      txt.push_back(hex_digit(b[7:4]));
      txt.push_back(hex_digit(b[3:0]));
    end
    if ($urandom_range(0, 5) == 0) txt.push_back(hex_digit(4'($urandom())));
    pos = $urandom_range(span, txt.size());
    if (kind >= 70 && kind < 76 && span > 0) begin
      i = $urandom_range(0, span - 1);
      txt[i] = txt[i] ^ (8'h01 << $urandom_range(0, 7));
    end else if (kind >= 76 && kind < 84) begin
      txt.insert(pos, junk_char());
    end else if (kind >= 84 && kind < 90) begin
      txt.insert(pos, NUL_CHAR);
      txt.push_back(junk_char());
    end else if (kind >= 90 && kind < 93 && span > 0) begin
      keep = $urandom_range(0, span - 1);
      while (txt.size() > keep) void'(txt.pop_back());
    end else if (kind >= 93 && kind < 96) begin
      txt.delete();
      repeat ($urandom_range(1, 12)) txt.push_back(8'($urandom()));
    end else if (kind >= 96) begin
      txt.push_back(junk_char());
    end
    // 0-6 newline, 7-8 end_of_text on last char, 9 newline with end_of_text
    ending = $urandom_range(0, 9);
    if (txt.size() == 0) ending = 0;
    for (i = 0; i < txt.size(); i++)
      send_char(txt[i], (ending >= 7) && (ending < 9) && (i == txt.size() - 1));
    if (ending < 7 || ending == 9) send_char(NEWLINE, ending == 9);
  endtask

  initial begin
    int unsigned goal, phase, nlines;
    logic [2:0]  plen;
    logic [31:0] chars;
    logic [4:0]  elen;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_PREFIX_LENGTH;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.ch = 8'h00;
    in_ch.end_of_text = 1'b0;
    cur_plen = PREFIX_LENGTH_RST;
    cur_chars = PREFIX_CHARS_RST;
    cur_elen = EXPECTED_LENGTH_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // default prefix, line too short to match
    send_text("01\n", 1'b0);
    quiesce();

    // empty prefix, zero length: bare header, also for a voided line
    set_config(3'd0, 32'h0, 5'd0);
    send_text("\n", 1'b0);
    send_text("g", 1'b1);
    quiesce();

    set_config(3'd1, ">", 5'd1);
    send_text(">Ff\n", 1'b0);
    send_text(">7e5", 1'b1);
    send_text(">A9", 1'b0);
    send_char(NUL_CHAR, 1'b0);
    send_text("q", 1'b1);
    send_text("\n", 1'b0);
    send_text("<12\n", 1'b0);
    send_char(">", 1'b0);
    send_char(8'hFF, 1'b1);

    // length change in the middle of a line
    send_char(">", 1'b0);
    quiesce();
    set_config(3'd1, ">", 5'd2);
    send_text("0102\n", 1'b0);

    goal = sent_chars + RANDOM_CHARS;
    phase = 0;
    while (sent_chars < goal) begin
      quiesce();
      if (phase == 0) begin
        plen = 3'd7;
        chars = 32'hFFFF_FFFF;
        elen = 5'd31;
      end else begin
        case ($urandom_range(0, 9))
          0: plen = 3'd0;
          1: plen = 3'($urandom_range(5, 7));
          default: plen = 3'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 9))
          0: chars = 32'h0;
          1: chars = 32'hFFFF_FFFF;
          2: chars = $urandom();
          default: chars = {8'($urandom_range(32, 126)), 8'($urandom_range(32, 126)),
                            8'($urandom_range(32, 126)), 8'($urandom_range(32, 126))};
        endcase
        case ($urandom_range(0, 7))
          0: elen = 5'd0;
          1: elen = 5'd31;
          2: elen = 5'($urandom_range(29, 30));
          default: elen = 5'($urandom_range(1, 8));
        endcase
      end
      set_config(plen, chars, elen);
      nlines = (elen > 5'd8) ? $urandom_range(1, 2) : $urandom_range(2, 6);
      repeat (nlines) send_random_line();
      phase++;
    end
    quiesce();

    if (fail_count == 0 && due_words == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== hex_line_to_stuffed_frame.f =====
hw/rtl/hlsf_pkg.sv
hw/rtl/hlsf_channels.sv
hw/rtl/hlsf_ram.sv
hw/rtl/hex_line_to_stuffed_frame.sv
sim/hlsf_frame_checker.sv
sim/hex_line_to_stuffed_frame_test.sv
